// ===== rtl/mscrc_pkg.sv =====
// Shared types, mode codes and per-byte CRC update functions for the
// multi-standard CRC engine. No dependencies.
package mscrc_pkg;

    typedef logic [3:0]  t_mode;
    typedef logic [7:0]  t_byte;
    typedef logic [31:0] t_crc;

    localparam t_mode MODE_ARC        = 4'd0;
    localparam t_mode MODE_MODBUS     = 4'd1;
    localparam t_mode MODE_DNP        = 4'd2;
    localparam t_mode MODE_SICK       = 4'd3;
    localparam t_mode MODE_XMODEM     = 4'd4;
    localparam t_mode MODE_CCITT_FFFF = 4'd5;
    localparam t_mode MODE_CCITT_1D0F = 4'd6;
    localparam t_mode MODE_KERMIT     = 4'd7;
    localparam t_mode MODE_CRC32      = 4'd8;

    localparam t_crc POLY_REF16  = 32'h0000_A001;
    localparam t_crc POLY_DNP    = 32'h0000_A6BC;
    localparam t_crc POLY_KERMIT = 32'h0000_8408;
    localparam t_crc POLY_REF32  = 32'hEDB8_8320;
    localparam logic [15:0] POLY_CCITT = 16'h1021;
    localparam logic [15:0] POLY_SICK  = 16'h8005;

    // Initial register value of a mode; unused codes fall back to ARC.
    function automatic t_crc init_of(input t_mode mode);
        t_crc v;
        unique case (mode) inside
            MODE_MODBUS, MODE_CCITT_FFFF: v = 32'h0000_FFFF;
            MODE_CCITT_1D0F:              v = 32'h0000_1D0F;
            MODE_CRC32:                   v = 32'hFFFF_FFFF;
            default:                      v = 32'h0000_0000;
        endcase
        return v;
    endfunction

    // LSB-first byte update, unrolled into an xor network.
    function automatic t_crc step_reflected(input t_crc crc, input t_byte b, input t_crc poly);
        t_crc c;
        c = crc ^ {24'h0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ poly) : (c >> 1);
        end
        return c;
    endfunction

    // MSB-first 16-bit byte update with the CCITT polynomial.
    function automatic logic [15:0] step_msb16(input logic [15:0] crc, input t_byte b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            c = c[15] ? ({c[14:0], 1'b0} ^ POLY_CCITT) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

    function automatic logic [15:0] swap16(input logic [15:0] v);
        return {v[7:0], v[15:8]};
    endfunction

endpackage

// ===== rtl/multi_standard_crc_engine_unit.sv =====
// Multi-standard byte-serial CRC engine (ARC, MODBUS, DNP, SICK, XMODEM,
// CCITT, KERMIT, CRC-32). Depends on mscrc_pkg and mscrc_step.
// Result path: the last byte goes from the input register to the result register, which
// raises o_valid and holds the CRC until it is taken.
// Throughput: one byte per cycle, set by the single xor network between the input
// register and the running CRC register; a last byte waits while a result is held.
// Synchronous active-low reset: mode ARC, CRC and previous byte cleared.
module multi_standard_crc_engine_unit (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  mscrc_pkg::t_mode     i_cfg_data,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  mscrc_pkg::t_byte     i_data_byte,
    input  logic                 i_last_byte,
    output logic                 o_valid,
    input  logic                 i_ready,
    output mscrc_pkg::t_crc      o_crc_value
);
    import mscrc_pkg::*;

    t_mode r_mode;
    t_crc  r_crc;
    t_byte r_prev;

    logic  r_in_valid;
    t_byte r_in_byte;
    logic  r_in_last;

    logic  r_out_valid;
    t_crc  r_out_crc;

    t_crc  next_crc;
    t_crc  final_crc;
    logic  advance;

    mscrc_step u_step (
        .i_mode     (r_mode),
        .i_crc      (r_crc),
        .i_prev     (r_prev),
        .i_byte     (r_in_byte),
        .o_next_crc (next_crc),
        .o_final    (final_crc)
    );

    // A byte that yields no result always moves on; a last byte needs room.
    assign advance = r_in_valid && (!r_in_last || !r_out_valid || i_ready);
    assign o_ready = !r_in_valid || advance;
    assign o_valid = r_out_valid;
    assign o_crc_value = r_out_crc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_byte <= i_data_byte;
            r_in_last <= i_last_byte;
        end
    end

    // Running state: mode write reloads, last byte reloads after finalizing.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_ARC;
            r_crc  <= '0;
            r_prev <= '0;
        end else if (i_cfg_we) begin
            r_mode <= i_cfg_data;
            r_crc  <= init_of(i_cfg_data);
            r_prev <= '0;
        end else if (advance) begin
            if (r_in_last) begin
                r_crc  <= init_of(r_mode);
                r_prev <= '0;
            end else begin
                r_crc  <= next_crc;
                r_prev <= r_in_byte;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in_last) begin
            r_out_crc <= final_crc;
        end
    end

endmodule

// ===== rtl/mscrc_step.sv =====
// Per-byte CRC update and finalization for all nine variants.
// Pure combinational xor network; depends on mscrc_pkg.
module mscrc_step (
    input  mscrc_pkg::t_mode i_mode,
    input  mscrc_pkg::t_crc  i_crc,
    input  mscrc_pkg::t_byte i_prev,
    input  mscrc_pkg::t_byte i_byte,
    output mscrc_pkg::t_crc  o_next_crc,
    output mscrc_pkg::t_crc  o_final
);
    import mscrc_pkg::*;

    logic [15:0] sick_shift;
    logic [15:0] low16;

    assign sick_shift = i_crc[15] ? ({i_crc[14:0], 1'b0} ^ POLY_SICK) : {i_crc[14:0], 1'b0};

    always_comb begin
        unique case (i_mode) inside
            MODE_MODBUS:
                o_next_crc = step_reflected({16'h0, i_crc[15:0]}, i_byte, POLY_REF16);
            MODE_DNP:
                o_next_crc = step_reflected({16'h0, i_crc[15:0]}, i_byte, POLY_DNP);
            MODE_SICK:
                o_next_crc = {16'h0, sick_shift ^ {i_prev, i_byte}};
            MODE_XMODEM, MODE_CCITT_FFFF, MODE_CCITT_1D0F:
                o_next_crc = {16'h0, step_msb16(i_crc[15:0], i_byte)};
            MODE_KERMIT:
                o_next_crc = step_reflected({16'h0, i_crc[15:0]}, i_byte, POLY_KERMIT);
            MODE_CRC32:
                o_next_crc = step_reflected(i_crc, i_byte, POLY_REF32);
            default:
                o_next_crc = step_reflected({16'h0, i_crc[15:0]}, i_byte, POLY_REF16);
        endcase
    end

    assign low16 = o_next_crc[15:0];

    always_comb begin
        unique case (i_mode) inside
            MODE_DNP:                o_final = {16'h0, swap16(~low16)};
            MODE_SICK, MODE_KERMIT:  o_final = {16'h0, swap16(low16)};
            MODE_CRC32:              o_final = ~o_next_crc;
            default:                 o_final = {16'h0, low16};
        endcase
    end

endmodule
